// File: hw/rtl/mtmr_pkg.sv
package mtmr_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_MIN = 8;
  localparam int TIME_WIDTH_MAX = 64;

  localparam int FIELD_W = 32;   // time_now and preset_ticks
  localparam int MODE_W  = 3;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;    // byte address of the last register (4)

  // register index (byte address / 4)
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_PRESET = 1'b1;

  // timer modes
  localparam logic [MODE_W-1:0] MODE_PULSE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EXT_PULSE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ON_DELAY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RET_ON    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OFF_DELAY = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  timer_mode;
    logic [FIELD_W-1:0] preset_ticks;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] time_now;
    logic               set_in;
    logic               reset_in;
  } in_item_t;

  typedef struct packed {
    logic timer_out;
    logic run_flag_out;
  } out_item_t;

endpackage

// File: hw/rtl/mtmr_in_if.sv
interface mtmr_in_if;
  logic                        valid;
  logic                        ready;
  logic [mtmr_pkg::FIELD_W-1:0] time_now;
  logic                        set_in;
  logic                        reset_in;

  modport source (output valid, output time_now, output set_in, output reset_in,
                  input ready);
  modport sink   (input valid, input time_now, input set_in, input reset_in,
                  output ready);
endinterface

// File: hw/rtl/mtmr_out_if.sv
interface mtmr_out_if;
  logic valid;
  logic ready;
  logic timer_out;
  logic run_flag_out;

  modport source (output valid, output timer_out, output run_flag_out, input ready);
  modport sink   (input valid, input timer_out, input run_flag_out, output ready);
endinterface

// File: hw/rtl/mtmr_cfg.sv
module mtmr_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtmr_pkg::ADDR_W-1:0] paddr,
  input  logic [mtmr_pkg::DATA_W-1:0] pwdata,
  output logic [mtmr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mtmr_pkg::cfg_t              cfg
);

  logic [mtmr_pkg::MODE_W-1:0]  mode_r;
  logic [mtmr_pkg::FIELD_W-1:0] preset_r;
  logic                         wr_en;
  logic                         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      preset_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        mtmr_pkg::REG_MODE:   mode_r   <= pwdata[mtmr_pkg::MODE_W-1:0];
        mtmr_pkg::REG_PRESET: preset_r <= pwdata[mtmr_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mtmr_pkg::REG_MODE:   prdata = {{(mtmr_pkg::DATA_W-mtmr_pkg::MODE_W){1'b0}}, mode_r};
      mtmr_pkg::REG_PRESET: prdata = preset_r;
      default:              prdata = '0;
    endcase
  end

  assign cfg.timer_mode   = mode_r;
  assign cfg.preset_ticks = preset_r;

endmodule

// File: hw/rtl/mtmr_core.sv
module mtmr_core #(
  parameter int TIME_WIDTH = mtmr_pkg::TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  mtmr_pkg::in_item_t  item,
  input  mtmr_pkg::cfg_t      cfg,
  output mtmr_pkg::out_item_t res
);

  // time values are kept in the low NW bits, elapsed time is TIME_WIDTH bits
  localparam int NW = (TIME_WIDTH < mtmr_pkg::FIELD_W) ? TIME_WIDTH : mtmr_pkg::FIELD_W;

  logic                  run_flag_r, run_flag_nxt;
  logic [NW-1:0]         start_time_r, start_time_nxt;

  logic [NW-1:0]         now;
  logic [NW-1:0]         preset;
  logic [NW-1:0]         start_eff;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  start_cond;
  logic                  running;
  logic                  flag_st;
  logic                  q;
  logic                  set;
  logic                  rst;

  assign now    = item.time_now[NW-1:0];
  assign preset = cfg.preset_ticks[NW-1:0];
  assign set    = item.set_in;
  assign rst    = item.reset_in;

  always_comb begin
    unique case (cfg.timer_mode)
      mtmr_pkg::MODE_PULSE,
      mtmr_pkg::MODE_EXT_PULSE,
      mtmr_pkg::MODE_ON_DELAY,
      mtmr_pkg::MODE_RET_ON:    start_cond = set & ~rst & ~run_flag_r;
      mtmr_pkg::MODE_OFF_DELAY: start_cond = set & ~rst;   // retriggers on every item with set high and reset low
      default:                  start_cond = 1'b0;
    endcase
  end

  assign start_eff = start_cond ? now : start_time_r;
  assign elapsed   = TIME_WIDTH'(now) - TIME_WIDTH'(start_eff);
  assign running   = elapsed < TIME_WIDTH'(preset);
  assign flag_st   = start_cond | run_flag_r;

  always_comb begin
    run_flag_nxt   = run_flag_r;
    start_time_nxt = start_eff;
    q              = 1'b0;
    unique case (cfg.timer_mode)
      mtmr_pkg::MODE_PULSE: begin
        run_flag_nxt = set & ~rst;
        q            = set & ~rst & running;
      end
      mtmr_pkg::MODE_EXT_PULSE: begin
        if (rst) begin
          run_flag_nxt = 1'b0;
        end else begin
          run_flag_nxt = (running | set) ? flag_st : 1'b0;
          q            = running;
        end
      end
      mtmr_pkg::MODE_ON_DELAY: begin
        if (rst) begin
          run_flag_nxt = 1'b0;
        end else begin
          run_flag_nxt = (running | set) ? flag_st : 1'b0;
          q            = ~running & set & flag_st;
        end
      end
      mtmr_pkg::MODE_RET_ON: begin
        if (rst) begin
          run_flag_nxt = 1'b0;
        end else begin
          run_flag_nxt = flag_st;
          q            = ~running & flag_st;
        end
      end
      mtmr_pkg::MODE_OFF_DELAY: begin
        if (rst) begin
          run_flag_nxt = 1'b0;
        end else begin
          run_flag_nxt = running & flag_st;
          q            = running & flag_st;
        end
      end
      default: ;  // unused mode: state kept
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_flag_r   <= 1'b0;
      start_time_r <= '0;
    end else if (step) begin
      run_flag_r   <= run_flag_nxt;
      start_time_r <= start_time_nxt;
    end
  end

  assign res.timer_out    = q;
  assign res.run_flag_out = run_flag_nxt;

endmodule

// File: hw/rtl/plc_style_multimode_timer.sv
// Multimode controller timer.
// An accepted item passes through the input register, then the result register.
// Throughput: 1 item per cycle unless output stalls; timer state updates in the same
// cycle the item leaves the input register, so the next item sees it with no bubble.
// Reset (rst_n low, synchronous): run flag, start time, registers and both pipeline
// valids clear; in_if.ready is low while reset is held.
module plc_style_multimode_timer #(
  parameter int TIME_WIDTH = mtmr_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mtmr_in_if.sink                     in_if,
  mtmr_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtmr_pkg::ADDR_W-1:0] paddr,
  input  logic [mtmr_pkg::DATA_W-1:0] pwdata,
  output logic [mtmr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  mtmr_pkg::cfg_t      cfg;
  mtmr_pkg::in_item_t  in_item_r;
  mtmr_pkg::out_item_t res;
  mtmr_pkg::out_item_t out_item_r;
  logic                in_vld_r;
  logic                out_vld_r;
  logic                advance;
  logic                in_acc;
  logic                step;

  assign advance     = ~out_vld_r | out_if.ready;
  assign in_if.ready = rst_n & (~in_vld_r | advance);
  assign in_acc      = in_if.valid & in_if.ready;
  assign step        = in_vld_r & advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.time_now <= in_if.time_now;
      in_item_r.set_in   <= in_if.set_in;
      in_item_r.reset_in <= in_if.reset_in;
    end
    if (step) begin
      out_item_r <= res;
    end
  end

  mtmr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtmr_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_if.valid        = out_vld_r;
  assign out_if.timer_out    = out_item_r.timer_out;
  assign out_if.run_flag_out = out_item_r.run_flag_out;

endmodule

// File: hw/rtl/mtmr_checker.sv
module mtmr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [mtmr_pkg::ADDR_W-1:0] paddr,
  input logic [mtmr_pkg::DATA_W-1:0] pwdata,
  input logic [mtmr_pkg::DATA_W-1:0] prdata
);

  // held result must stay offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // each rise of the result valid must trace back to an accepted item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching item");

  // mode register reads back what was written
  a_mode_rb: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[2] == mtmr_pkg::REG_MODE
    |=> (paddr[2] != mtmr_pkg::REG_MODE ||
         prdata[mtmr_pkg::MODE_W-1:0] == $past(pwdata[mtmr_pkg::MODE_W-1:0])))
    else $error("mode register readback mismatch");

endmodule

bind plc_style_multimode_timer mtmr_checker u_mtmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mtmr_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int LONG_HOLD     = 64;
  localparam int RANDOM_PHASES = 14;
  localparam logic [MODE_W-1:0]  MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0]  MODE_SPARE_HI = 3'd7;
  localparam logic [FIELD_W-1:0] TICK_MAX      = '1;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] preset;
    in_item_t           item;
    bit                 typed;
    out_item_t          want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  mtmr_in_if  in_ch();
  mtmr_out_if out_ch();

  plc_style_multimode_timer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // timer model state and its copy of the registers
  logic [MODE_W-1:0]  cfg_mode   = MODE_PULSE;
  logic [FIELD_W-1:0] cfg_preset = '0;
  logic               pred_run   = 1'b0;
  logic [FIELD_W-1:0] pred_start = '0;

  out_item_t expected_results[$];
  plan_row_t directed_plan[$];

  int errors           = 0;
  int items_sent       = 0;
  int results_checked  = 0;
  int settings_applied = 0;
  int idle_cycles      = 0;
  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int hold_left        = 0;
  bit hold_request     = 1'b0;

  function automatic out_item_t timer_step(input in_item_t it);
    out_item_t          res;
    logic [FIELD_W-1:0] elapsed;
    logic               running;
    res = '0;
    case (cfg_mode)
      MODE_PULSE: begin
        if (!it.set_in || it.reset_in) begin
          pred_run = 1'b0;
        end else begin
          if (!pred_run) begin
            pred_run   = 1'b1;
            pred_start = it.time_now;
          end
          elapsed = it.time_now - pred_start;
          res.timer_out = (elapsed < cfg_preset);
        end
      end
      MODE_EXT_PULSE, MODE_ON_DELAY, MODE_RET_ON: begin
        if (it.reset_in) begin
          pred_run = 1'b0;
        end else begin
          if (it.set_in && !pred_run) begin
            pred_run   = 1'b1;
            pred_start = it.time_now;
          end
          elapsed = it.time_now - pred_start;
          running = (elapsed < cfg_preset);
          if (cfg_mode == MODE_EXT_PULSE) begin
            if (running) res.timer_out = 1'b1;
            else if (!it.set_in) pred_run = 1'b0;
          end else if (cfg_mode == MODE_ON_DELAY) begin
            if (!running) begin
              if (!it.set_in) pred_run = 1'b0;
              res.timer_out = pred_run;
            end
          end else if (!running) begin
            res.timer_out = pred_run;
          end
        end
      end
      MODE_OFF_DELAY: begin
        if (it.reset_in) begin
          pred_run = 1'b0;
        end else begin
          // off-delay retriggers on every item with set high
          if (it.set_in) begin
            pred_run   = 1'b1;
            pred_start = it.time_now;
          end
          elapsed = it.time_now - pred_start;
          if (elapsed < cfg_preset) res.timer_out = pred_run;
          else pred_run = 1'b0;
        end
      end
      default: ;  // unused codes leave the state alone
    endcase
    res.run_flag_out = pred_run;
    return res;
  endfunction

  function automatic void add_row(input logic [MODE_W-1:0] mode,
                                  input logic [FIELD_W-1:0] preset,
                                  input logic [FIELD_W-1:0] now, input logic set_in,
                                  input logic reset_in, input bit typed,
                                  input logic q, input logic flag);
    plan_row_t row;
    row.mode               = mode;
    row.preset             = preset;
    row.item.time_now      = now;
    row.item.set_in        = set_in;
    row.item.reset_in      = reset_in;
    row.typed              = typed;
    row.want.timer_out     = q;
    row.want.run_flag_out  = flag;
    directed_plan.push_back(row);
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.time_now <= it.time_now;
    in_ch.set_in   <= it.set_in;
    in_ch.reset_in <= it.reset_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = timer_step(it);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // write, then read back through the same port
  task automatic program_register(input logic idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd !== val) begin
      $display("%0t: register %0d readback expected %h got %h", $time, idx, val, rd);
      errors++;
    end
  endtask

  task automatic apply_setting(input logic [MODE_W-1:0] mode,
                               input logic [FIELD_W-1:0] preset);
    drain_results();
    program_register(REG_MODE, DATA_W'(mode));
    program_register(REG_PRESET, preset);
    cfg_mode   = mode;
    cfg_preset = preset;
    settings_applied++;
  endtask

  // result side: backpressure, long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result timer_out=%b run_flag_out=%b",
                 $time, out_ch.timer_out, out_ch.run_flag_out);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.timer_out !== want.timer_out) begin
          $display("%0t: timer_out expected %b got %b",
                   $time, want.timer_out, out_ch.timer_out);
          errors++;
        end
        if (out_ch.run_flag_out !== want.run_flag_out) begin
          $display("%0t: run_flag_out expected %b got %b",
                   $time, want.run_flag_out, out_ch.run_flag_out);
          errors++;
        end
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, expected_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    plan_row_t          row;
    in_item_t           it;
    out_item_t          no_want;
    logic [MODE_W-1:0]  mode_order [0:4];
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] preset;
    logic [FIELD_W-1:0] tick;
    logic               set_lvl;
    int                 n_items;

    no_want    = '0;
    mode_order = '{MODE_PULSE, MODE_EXT_PULSE, MODE_ON_DELAY, MODE_RET_ON, MODE_OFF_DELAY};

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.time_now <= '0;
    in_ch.set_in   <= 1'b0;
    in_ch.reset_in <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mode, preset, time, set, reset, typed, timer_out, run_flag_out
    add_row(MODE_PULSE,     '0,           '0,           0, 0, 1, 0, 0);  // never started
    add_row(MODE_PULSE,     '0,           TICK_MAX,     1, 0, 1, 0, 1);  // zero preset
    add_row(MODE_PULSE,     32'd5,        32'd100,      1, 1, 1, 0, 0);
    add_row(MODE_PULSE,     32'd5,        32'd100,      1, 0, 0, 0, 0);
    add_row(MODE_PULSE,     32'd5,        32'd104,      1, 0, 0, 0, 0);
    add_row(MODE_PULSE,     32'd5,        32'd105,      1, 0, 0, 0, 0);
    add_row(MODE_PULSE,     32'd5,        32'd106,      0, 0, 1, 0, 0);
    add_row(MODE_EXT_PULSE, 32'd10,       32'hFFFFFFFA, 1, 0, 0, 0, 0);
    add_row(MODE_EXT_PULSE, 32'd10,       32'd3,        0, 0, 0, 0, 0);  // tick wraps
    add_row(MODE_EXT_PULSE, 32'd10,       32'd4,        0, 0, 0, 0, 0);
    add_row(MODE_ON_DELAY,  32'd3,        32'd50,       1, 0, 0, 0, 0);
    add_row(MODE_ON_DELAY,  32'd3,        32'd53,       1, 0, 0, 0, 0);
    add_row(MODE_ON_DELAY,  32'd3,        32'd54,       0, 0, 1, 0, 0);
    add_row(MODE_RET_ON,    32'd4,        32'd10,       1, 0, 0, 0, 0);
    add_row(MODE_RET_ON,    32'd4,        32'd12,       0, 0, 0, 0, 0);
    add_row(MODE_RET_ON,    32'd4,        32'd20,       0, 0, 0, 0, 0);
    add_row(MODE_RET_ON,    32'd4,        32'd21,       0, 1, 1, 0, 0);
    add_row(MODE_OFF_DELAY, 32'd6,        32'd30,       1, 0, 0, 0, 0);
    add_row(MODE_OFF_DELAY, 32'd6,        32'd35,       0, 0, 0, 0, 0);
    add_row(MODE_OFF_DELAY, 32'd6,        32'd36,       0, 0, 1, 0, 0);
    add_row(MODE_OFF_DELAY, TICK_MAX,     TICK_MAX,     1, 0, 0, 0, 0);
    add_row(MODE_OFF_DELAY, TICK_MAX,     32'd5,        0, 0, 0, 0, 0);
    add_row(MODE_SPARE_LO,  TICK_MAX,     32'd1,        0, 1, 1, 0, 1);  // ignored
    add_row(MODE_SPARE_HI,  TICK_MAX,     32'd2,        1, 0, 1, 0, 1);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.mode !== cfg_mode || row.preset !== cfg_preset)
        apply_setting(row.mode, row.preset);
      send_item(row.item, row.typed, row.want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      if (p == RANDOM_PHASES - 1) mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      else mode = mode_order[p % 5];
      case (p % 7)
        1: preset = '0;
        2: preset = TICK_MAX;
        5: preset = $urandom();
        default: preset = $urandom_range(24, 1);
      endcase
      apply_setting(mode, preset);

      // runs of slowly advancing ticks, sometimes just below the wrap point
      tick    = ($urandom_range(3) == 0) ? TICK_MAX - $urandom_range(60) : $urandom();
      set_lvl = 1'($urandom_range(1));
      n_items = (mode > MODE_OFF_DELAY) ? 20 : 126;
      for (int n = 0; n < n_items; n++) begin
        if (p == 4 && n == 40) hold_request = 1'b1;
        if (p == 6 && n == 60) drain_results();
        if ($urandom_range(99) < 8) begin
          it.time_now = $urandom();
        end else begin
          tick += $urandom_range(3);
          it.time_now = tick;
        end
        if ($urandom_range(7) == 0) set_lvl = ~set_lvl;
        it.set_in   = set_lvl;
        it.reset_in = ($urandom_range(99) < 5);
        send_item(it, 1'b0, no_want);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Checked %0d results from %0d items across %0d register settings.",
             results_checked, items_sent, settings_applied);
    $display("All five modes and unused codes, zero/full presets, tick wrap, flow control.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mtmr_pkg.sv
hw/rtl/mtmr_in_if.sv
hw/rtl/mtmr_out_if.sv
hw/rtl/mtmr_cfg.sv
hw/rtl/mtmr_core.sv
hw/rtl/plc_style_multimode_timer.sv
hw/rtl/mtmr_checker.sv
sim/testbench.sv
